@@ design/circular_fifo_queue_macros.svh @@
// Assertion macros for the circular FIFO queue checker.
`ifndef CIRCULAR_FIFO_QUEUE_MACROS_SVH
`define CIRCULAR_FIFO_QUEUE_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define CFQ_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define CFQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/cfq_pkg.sv @@
// Shared widths, action and status codes and state encoding for the circular FIFO queue.
package cfq_pkg;

  localparam int ACTION_W = 3;
  localparam int STATUS_W = 2;
  localparam int DATA_W   = 32;

  // Action codes carried by an input transaction
  localparam logic [ACTION_W-1:0] ACT_INSERT     = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_DELETE     = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_DISPLAY    = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_PEEK_FRONT = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_PEEK_REAR  = 3'd4;

  // Status codes of a result transaction
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 2'd2;

  // Controller states, one-hot
  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_READ = 2'b10
  } state_t;

  typedef logic signed [DATA_W-1:0] data_t;

endpackage

@@ design/cfq_if.sv @@
// Valid/ready channel interfaces for the input and result transactions.
interface cfq_in_if;
  logic                           valid;
  logic                           ready;
  logic [cfq_pkg::ACTION_W-1:0]   action;
  logic signed [cfq_pkg::DATA_W-1:0] value;

  modport source (output valid, output action, output value, input ready);
  modport sink   (input valid, input action, input value, output ready);
endinterface

interface cfq_out_if;
  logic                           valid;
  logic                           ready;
  logic [cfq_pkg::STATUS_W-1:0]   status;
  logic signed [cfq_pkg::DATA_W-1:0] data;
  logic                           last;

  modport source (output valid, output status, output data, output last, input ready);
  modport sink   (input valid, input status, input data, input last, output ready);
endinterface

@@ design/cfq_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
module cfq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port, and read data that holds until the next read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ design/circular_fifo_queue.sv @@
// Circular FIFO queue of signed 32-bit words held in a single RAM.
//
// Usage:
//   in_if  : valid/ready channel; each transaction carries an action and a value
//            (insert, delete, display all, peek front, peek rear).
//   out_if : valid/ready channel; each transaction carries status, data and last.
//   Insert and every error answer are registered in the result stage at the
//   edge that takes the input transaction: result valid in the next cycle.
//   Delete and both peeks read the RAM: the element passes through the RAM read register, then the result register.
//   Display reads one element per cycle from head to tail while the result
//   register is free or being drained; occupancy results in all, last on the final.
//   A new transaction is taken when the controller is idle and the result
//   register is empty or being drained in the same cycle: back-to-back for
//   inserts; a read or display holds input ready low until its last result is loaded.
//   The RAM's one registered read port sets these limits.
//   Undefined actions are taken and dropped without a result.
//   Reset (rst_n low, synchronous) empties the queue; stored words are not cleared.
//   When the receiver stalls, the result register holds and input ready drops.
module circular_fifo_queue #(
  parameter int DEPTH = 64
) (
  input  logic clk,
  input  logic rst_n,
  cfq_in_if.sink    in_if,
  cfq_out_if.source out_if
);

  localparam int AW = $clog2(DEPTH);
  localparam int OW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
  localparam logic [OW-1:0] FULL_CNT  = OW'(DEPTH);

  function automatic logic [AW-1:0] next_slot(input logic [AW-1:0] i);
    return (i == LAST_SLOT) ? '0 : i + AW'(1);
  endfunction

  function automatic logic [AW-1:0] prev_slot(input logic [AW-1:0] i);
    return (i == '0) ? LAST_SLOT : i - AW'(1);
  endfunction

  cfq_pkg::state_t state_r, state_nxt;
  logic [AW-1:0] head_r, head_nxt;
  logic [AW-1:0] tail_r, tail_nxt;
  logic [OW-1:0] occ_r, occ_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [OW-1:0] rem_r, rem_nxt;

  logic                          out_valid_r;
  logic [cfq_pkg::STATUS_W-1:0]  out_status_r;
  cfq_pkg::data_t                out_data_r;
  logic                          out_last_r;

  logic                          out_free;
  logic                          in_fire;
  logic                          out_load;
  logic [cfq_pkg::STATUS_W-1:0]  ld_status;
  cfq_pkg::data_t                ld_data;
  logic                          ld_last;

  logic                          wr_en;
  logic                          rd_en;
  logic [AW-1:0]                 rd_addr;
  logic [cfq_pkg::DATA_W-1:0]    rd_data;

  assign out_free    = !out_valid_r || out_if.ready;
  assign in_if.ready = (state_r == cfq_pkg::S_IDLE) && out_free;
  assign in_fire     = in_if.valid && in_if.ready;

  // Element store
  cfq_ram #(
    .WIDTH (cfq_pkg::DATA_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (tail_r),
    .wr_data (in_if.value),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Controller: pointer update, RAM access and result selection
  always_comb begin
    state_nxt  = state_r;
    head_nxt   = head_r;
    tail_nxt   = tail_r;
    occ_nxt    = occ_r;
    rd_ptr_nxt = rd_ptr_r;
    rem_nxt    = rem_r;
    wr_en      = 1'b0;
    rd_en      = 1'b0;
    rd_addr    = head_r;
    out_load   = 1'b0;
    ld_status  = cfq_pkg::ST_OK;
    ld_data    = '0;
    ld_last    = 1'b1;

    unique case (state_r)
      cfq_pkg::S_IDLE: begin
        if (in_fire) begin
          unique case (in_if.action) inside
            cfq_pkg::ACT_INSERT: begin
              out_load = 1'b1;
              if (occ_r == FULL_CNT) begin
                ld_status = cfq_pkg::ST_OVERFLOW;
              end else begin
                wr_en    = 1'b1;
                tail_nxt = next_slot(tail_r);
                occ_nxt  = occ_r + OW'(1);
                ld_data  = in_if.value;
              end
            end
            cfq_pkg::ACT_DELETE, cfq_pkg::ACT_DISPLAY,
            cfq_pkg::ACT_PEEK_FRONT, cfq_pkg::ACT_PEEK_REAR: begin
              if (occ_r == '0) begin
                out_load  = 1'b1;
                ld_status = cfq_pkg::ST_UNDERFLOW;
              end else begin
                rd_en     = 1'b1;
                rd_addr   = (in_if.action == cfq_pkg::ACT_PEEK_REAR) ?
                            prev_slot(tail_r) : head_r;
                rd_ptr_nxt = rd_addr;
                rem_nxt   = (in_if.action == cfq_pkg::ACT_DISPLAY) ? occ_r : OW'(1);
                state_nxt = cfq_pkg::S_READ;
                if (in_if.action == cfq_pkg::ACT_DELETE) begin
                  head_nxt = next_slot(head_r);
                  occ_nxt  = occ_r - OW'(1);
                end
              end
            end
            default: ;
          endcase
        end
      end
      cfq_pkg::S_READ: begin
        // rd_data holds the element at rd_ptr_r until the next read
        rd_addr = next_slot(rd_ptr_r);
        if (out_free) begin
          out_load = 1'b1;
          ld_data  = rd_data;
          ld_last  = (rem_r == OW'(1));
          if (rem_r == OW'(1)) begin
            state_nxt = cfq_pkg::S_IDLE;
          end else begin
            rem_nxt    = rem_r - OW'(1);
            rd_en      = 1'b1;
            rd_ptr_nxt = rd_addr;
          end
        end
      end
      default: state_nxt = cfq_pkg::S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= cfq_pkg::S_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      occ_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      occ_r       <= occ_nxt;
      out_valid_r <= out_load ? 1'b1 : (out_if.ready ? 1'b0 : out_valid_r);
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    rd_ptr_r <= rd_ptr_nxt;
    rem_r    <= rem_nxt;
    if (out_load) begin
      out_status_r <= ld_status;
      out_data_r   <= ld_data;
      out_last_r   <= ld_last;
    end
  end

  assign out_if.valid  = out_valid_r;
  assign out_if.status = out_status_r;
  assign out_if.data   = out_data_r;
  assign out_if.last   = out_last_r;

endmodule

@@ design/cfq_checker.sv @@
// Port-level checker for the circular FIFO queue and its bind to the top level.
`include "circular_fifo_queue_macros.svh"

module cfq_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic [cfq_pkg::ACTION_W-1:0]  in_action,
  input logic [cfq_pkg::DATA_W-1:0]    in_value,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [cfq_pkg::STATUS_W-1:0]  out_status,
  input logic [cfq_pkg::DATA_W-1:0]    out_data,
  input logic                          out_last
);

  // A stalled result transaction keeps its payload
  `CFQ_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_status) && $stable(out_data) && $stable(out_last), "result changed while stalled")

  // Errors carry zero data and close the item
  `CFQ_ASSERT_NOW(a_err_zero, out_valid && (out_status != cfq_pkg::ST_OK), (out_data == '0) && out_last, "error result with data or without last")

  // An accepted insert answers on the next cycle with its value or overflow
  `CFQ_ASSERT_NEXT(a_insert_echo, in_valid && in_ready && (in_action == cfq_pkg::ACT_INSERT), out_valid && (out_status == cfq_pkg::ST_OVERFLOW || (out_status == cfq_pkg::ST_OK && out_data == $past(in_value))), "insert result missing or wrong")

  // No new transaction is taken in the middle of a display
  `CFQ_ASSERT_NOW(a_no_accept_mid, out_valid && !out_last, !in_ready, "input taken before display finished")

endmodule

bind circular_fifo_queue cfq_checker u_cfq_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_if.valid),
  .in_ready   (in_if.ready),
  .in_action  (in_if.action),
  .in_value   (in_if.value),
  .out_valid  (out_if.valid),
  .out_ready  (out_if.ready),
  .out_status (out_if.status),
  .out_data   (out_if.data),
  .out_last   (out_if.last)
);

@@ tb/sv/tb.sv @@
// Self-checking testbench for the circular FIFO queue: directed and random actions.
`timescale 1ns / 1ps

module tb;

  localparam int CLK_PERIOD   = 8;
  localparam int QDEPTH       = 64;
  localparam int PTR_W        = $clog2(QDEPTH);
  localparam int CNT_W        = PTR_W + 1;
  localparam int CYCLE_LIMIT  = 500_000;
  localparam int TAIL_CYCLES  = 16;
  localparam int MAX_REPORTS  = 10;

  // Action codes the block takes and drops without a result
  localparam logic [cfq_pkg::ACTION_W-1:0] ACT_RSVD_LO = 3'd5;
  localparam logic [cfq_pkg::ACTION_W-1:0] ACT_RSVD_HI = 3'd7;

  localparam cfq_pkg::data_t WORD_MIN = 32'sh8000_0000;
  localparam cfq_pkg::data_t WORD_MAX = 32'sh7FFF_FFFF;

  typedef struct packed {
    logic [cfq_pkg::STATUS_W-1:0] status;
    cfq_pkg::data_t               data;
    logic                         last;
  } answer_t;

  logic clk = 1'b0;
  logic rst_n;

  cfq_in_if  in_ch ();
  cfq_out_if out_ch ();

  circular_fifo_queue #(.DEPTH(QDEPTH)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Queue contents as the testbench tracks them
  cfq_pkg::data_t   shadow_mem [QDEPTH];
  logic [PTR_W-1:0] shadow_head;
  logic [PTR_W-1:0] shadow_tail;
  logic [CNT_W-1:0] shadow_fill;

  answer_t answers_due [$];

  int in_idle_pct  = 0;
  int out_idle_pct = 0;
  int items_accepted  = 0;
  int results_checked = 0;
  int overflows_seen  = 0;
  int underflows_seen = 0;
  int displays_sent   = 0;
  int mismatch_count  = 0;
  int cycle_count     = 0;

  function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] slot);
    return (slot == PTR_W'(QDEPTH - 1)) ? '0 : slot + PTR_W'(1);
  endfunction

  function automatic void queue_answer(input logic [cfq_pkg::STATUS_W-1:0] status,
                                       input cfq_pkg::data_t data, input logic last);
    answer_t a;
    a.status = status;
    a.data   = data;
    a.last   = last;
    answers_due.push_back(a);
  endfunction

  // Apply one accepted action to the shadow queue and list its results
  function automatic void predict_queue_op(input logic [cfq_pkg::ACTION_W-1:0] act,
                                           input cfq_pkg::data_t val);
    logic [PTR_W-1:0] slot;
    case (act) inside
      cfq_pkg::ACT_INSERT: begin
        if (shadow_fill == CNT_W'(QDEPTH)) begin
          queue_answer(cfq_pkg::ST_OVERFLOW, '0, 1'b1);
        end else begin
          shadow_mem[shadow_tail] = val;
          shadow_tail = next_slot(shadow_tail);
          shadow_fill++;
          queue_answer(cfq_pkg::ST_OK, val, 1'b1);
        end
      end
      cfq_pkg::ACT_DELETE: begin
        if (shadow_fill == '0) begin
          queue_answer(cfq_pkg::ST_UNDERFLOW, '0, 1'b1);
        end else begin
          queue_answer(cfq_pkg::ST_OK, shadow_mem[shadow_head], 1'b1);
          shadow_head = next_slot(shadow_head);
          shadow_fill--;
        end
      end
      cfq_pkg::ACT_DISPLAY: begin
        if (shadow_fill == '0) begin
          queue_answer(cfq_pkg::ST_UNDERFLOW, '0, 1'b1);
        end else begin
          slot = shadow_head;
          for (int k = 0; k < int'(shadow_fill); k++) begin
            queue_answer(cfq_pkg::ST_OK, shadow_mem[slot], k == int'(shadow_fill) - 1);
            slot = next_slot(slot);
          end
        end
      end
      cfq_pkg::ACT_PEEK_FRONT, cfq_pkg::ACT_PEEK_REAR: begin
        if (shadow_fill == '0) begin
          queue_answer(cfq_pkg::ST_UNDERFLOW, '0, 1'b1);
        end else begin
          slot = (act == cfq_pkg::ACT_PEEK_FRONT) ? shadow_head
               : (shadow_tail == '0) ? PTR_W'(QDEPTH - 1) : shadow_tail - PTR_W'(1);
          queue_answer(cfq_pkg::ST_OK, shadow_mem[slot], 1'b1);
        end
      end
      default: ;  // reserved codes: no result, no state change
    endcase
  endfunction

  // Send one transaction; entered and left at a falling edge
  task automatic send_item(input logic [cfq_pkg::ACTION_W-1:0] act,
                           input cfq_pkg::data_t val);
    while ($urandom_range(0, 99) < in_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid  <= 1'b1;
    in_ch.action <= act;
    in_ch.value  <= val;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predict_queue_op(act, val);
    items_accepted++;
    if (act == cfq_pkg::ACT_DISPLAY) displays_sent++;
    @(negedge clk);
  endtask

  task automatic release_input();
    in_ch.valid <= 1'b0;
  endtask

  task automatic wait_results_drained();
    release_input();
    while (answers_due.size() != 0) @(negedge clk);
  endtask

  function automatic cfq_pkg::data_t rand_word();
    case ($urandom_range(0, 7))
      0:       return WORD_MIN;
      1:       return WORD_MAX;
      2:       return '0;
      default: return cfq_pkg::data_t'($urandom);
    endcase
  endfunction

  // Reads on an empty queue and the reserved codes
  task automatic test_empty_queue();
    send_item(cfq_pkg::ACT_DELETE, rand_word());
    send_item(cfq_pkg::ACT_DISPLAY, rand_word());
    send_item(cfq_pkg::ACT_PEEK_FRONT, rand_word());
    send_item(cfq_pkg::ACT_PEEK_REAR, rand_word());
    for (int a = int'(ACT_RSVD_LO); a <= int'(ACT_RSVD_HI); a++)
      send_item(cfq_pkg::ACTION_W'(a), WORD_MAX);
    wait_results_drained();
  endtask

  // Extreme values through every action
  task automatic test_extremes();
    send_item(cfq_pkg::ACT_INSERT, WORD_MIN);
    send_item(cfq_pkg::ACT_INSERT, WORD_MAX);
    send_item(cfq_pkg::ACT_INSERT, '0);
    send_item(cfq_pkg::ACT_INSERT, -32'sd1);
    send_item(cfq_pkg::ACT_PEEK_FRONT, WORD_MAX);
    send_item(cfq_pkg::ACT_PEEK_REAR, WORD_MIN);
    send_item(cfq_pkg::ACT_DISPLAY, '0);
    send_item(cfq_pkg::ACT_DELETE, '0);
    send_item(cfq_pkg::ACT_DELETE, '0);
    send_item(cfq_pkg::ACT_PEEK_FRONT, '0);
    send_item(cfq_pkg::ACT_DISPLAY, '0);
    send_item(cfq_pkg::ACT_DELETE, '0);
    send_item(cfq_pkg::ACT_DELETE, '0);
    send_item(cfq_pkg::ACT_DELETE, '0);
    send_item(cfq_pkg::ACT_DISPLAY, '0);
    wait_results_drained();
  endtask

  // Fill to capacity, overflow, then drain so both pointers wrap around
  task automatic test_full_wrap();
    for (int i = 0; i < QDEPTH; i++) send_item(cfq_pkg::ACT_INSERT, rand_word());
    send_item(cfq_pkg::ACT_INSERT, WORD_MAX);
    send_item(cfq_pkg::ACT_PEEK_REAR, '0);
    send_item(cfq_pkg::ACT_DISPLAY, '0);
    // hold the sender until the queue has answered everything
    wait_results_drained();
    while (shadow_fill != '0) send_item(cfq_pkg::ACT_DELETE, rand_word());
    send_item(cfq_pkg::ACT_PEEK_REAR, '0);
    wait_results_drained();
  endtask

  // Random action mix; inserts lead so the occupancy wanders upward
  task automatic test_random(input int n_items, input int in_pct, input int out_pct);
    int pick;
    logic [cfq_pkg::ACTION_W-1:0] act;
    in_idle_pct  = in_pct;
    out_idle_pct = out_pct;
    for (int i = 0; i < n_items; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 42)      act = cfq_pkg::ACT_INSERT;
      else if (pick < 72) act = cfq_pkg::ACT_DELETE;
      else if (pick < 81) act = cfq_pkg::ACT_PEEK_FRONT;
      else if (pick < 90) act = cfq_pkg::ACT_PEEK_REAR;
      else if (pick < 96) act = cfq_pkg::ACT_DISPLAY;
      else act = ACT_RSVD_LO +
                 cfq_pkg::ACTION_W'($urandom_range(0, int'(ACT_RSVD_HI - ACT_RSVD_LO)));
      send_item(act, rand_word());
    end
    wait_results_drained();
  endtask

  // Receiver stalls, redrawn each cycle
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ch.ready <= ($urandom_range(0, 99) >= out_idle_pct);
    end
  end

  // Result checker
  always @(posedge clk) begin
    answer_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (answers_due.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("%0t: unexpected result status=%0d data=%0d last=%0b", $realtime,
                   out_ch.status, out_ch.data, out_ch.last);
      end else begin
        want = answers_due.pop_front();
        results_checked++;
        if (want.status == cfq_pkg::ST_OVERFLOW)  overflows_seen++;
        if (want.status == cfq_pkg::ST_UNDERFLOW) underflows_seen++;
        if (out_ch.status !== want.status || out_ch.data !== want.data ||
            out_ch.last !== want.last) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("%0t: mismatch exp status=%0d data=%0d last=%0b, got %0d/%0d/%0b",
                     $realtime, want.status, want.data, want.last,
                     out_ch.status, out_ch.data, out_ch.last);
        end
      end
    end
  end

  // Watchdog
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb failed");
    $finish;
  end

  initial begin
    rst_n        = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.action = cfq_pkg::ACT_INSERT;
    in_ch.value  = '0;
    shadow_head  = '0;
    shadow_tail  = '0;
    shadow_fill  = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // sender idles now and then, receiver often
    in_idle_pct  = 6;
    out_idle_pct = 47;
    test_empty_queue();
    test_extremes();
    // sender idles often, receiver now and then
    in_idle_pct  = 47;
    out_idle_pct = 6;
    test_full_wrap();
    // no idling on either side
    test_random(12, 0, 0);

    release_input();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (answers_due.size() != 0) mismatch_count += answers_due.size();
    $display("Sent %0d actions (%0d displays); checked %0d results in %0d cycles.",
             items_accepted, displays_sent, results_checked, cycle_count);
    $display("Overflow results: %0d, underflow results: %0d, mismatches: %0d.",
             overflows_seen, underflows_seen, mismatch_count);
    if (mismatch_count == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+design
design/cfq_pkg.sv
design/cfq_if.sv
design/cfq_ram.sv
design/circular_fifo_queue.sv
design/cfq_checker.sv
tb/sv/tb.sv
